// ===== rtl/tbws_pkg.sv =====
// Shared types, constants and character helpers for the text word signature block.
package tbws_pkg;

  // Only the low six bits of either hash ever select a signature bit, and the
  // low bits of a product depend only on the low bits of its operands.
  localparam int HASH_W = 6;
  localparam int SIG_W  = 2 ** HASH_W;
  localparam int SEED_W = 32;
  localparam int BYTE_W = 8;

  localparam int PREFIX_LIMIT_DEF = 4;

  localparam logic [SEED_W-1:0] FNV_PRIME      = 32'd16777619;
  localparam logic [SEED_W-1:0] LENGTH_MIX     = 32'd2654435761;
  localparam logic [SEED_W-1:0] SEED_ONE_RESET = 32'd2166136261;
  localparam logic [SEED_W-1:0] SEED_TWO_RESET = 32'd2246822519;

  localparam logic [HASH_W-1:0] FNV_PRIME_LO  = FNV_PRIME[HASH_W-1:0];
  localparam logic [HASH_W-1:0] LENGTH_MIX_LO = LENGTH_MIX[HASH_W-1:0];

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SEED = 2'd1;

  // Contents of the input register stage.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;
  } in_word_t;

  function automatic logic is_word_char(input logic [BYTE_W-1:0] b);
    return (b >= 8'h80) || ((b >= 8'h30) && (b <= 8'h39)) ||
           ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  // Lowercased character, low hash bits only.
  function automatic logic [HASH_W-1:0] fold_char(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = b;
    if ((b >= 8'h41) && (b <= 8'h5A)) begin
      c = b + 8'h20;
    end
    return c[HASH_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                  input logic [HASH_W-1:0] c);
    logic [2*HASH_W-1:0] prod;
    prod = (h ^ c) * FNV_PRIME_LO;
    return prod[HASH_W-1:0];
  endfunction

endpackage

// ===== rtl/tbws_in_stage.sv =====
// Input register stage: captures one text word and holds it until the core takes it.
module tbws_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [tbws_pkg::BYTE_W-1:0] in_text_byte,
  input  logic                      in_last_byte,
  input  logic                      go,
  output tbws_pkg::in_word_t        stage
);
  import tbws_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;
  logic              accept;

  assign in_stall = valid_r && !go;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (go) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_text_byte;
      last_r <= in_last_byte;
    end
  end

  assign stage = '{valid: valid_r, text_byte: byte_r, last_byte: last_r};

endmodule

// ===== rtl/tbws_accum.sv =====
// Word hashing, signature accumulation and the result register.
module tbws_accum #(
  parameter int PREFIX_LIMIT = tbws_pkg::PREFIX_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tbws_pkg::in_word_t          stage,
  input  logic [tbws_pkg::HASH_W-1:0] seed_one,
  input  logic [tbws_pkg::HASH_W-1:0] seed_two,
  output logic                        go,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tbws_pkg::SIG_W-1:0]  out_signature
);
  import tbws_pkg::*;

  localparam int PW = $clog2(PREFIX_LIMIT + 1);
  localparam logic [PW-1:0] LIMIT = PW'(PREFIX_LIMIT);

  logic [HASH_W-1:0] h1_r, h1_nxt, h2_r, h2_nxt;
  logic [PW-1:0]     pt_r, pt_nxt;
  logic [SIG_W-1:0]  acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SIG_W-1:0]  out_sig_r;

  logic              word;
  logic              finish;
  logic [HASH_W-1:0] h1_base, h2_base, h1_word, h2_word, h1_fin, h2_fin;
  logic [PW-1:0]     pt_word, pt_fin;
  logic [2*HASH_W-1:0] mix_prod;
  logic [HASH_W-1:0] mix;
  logic [SIG_W-1:0]  sig_new;

  // A final word waits while the result register is full and stalled.
  assign go = stage.valid && (!stage.last_byte || !out_valid_r || !out_stall);

  always_comb begin
    word    = is_word_char(stage.text_byte);
    h1_base = (pt_r == '0) ? seed_one : h1_r;
    h2_base = (pt_r == '0) ? seed_two : h2_r;
    h1_word = h1_base;
    h2_word = h2_base;
    pt_word = pt_r;
    if (pt_r < LIMIT) begin
      h1_word = hash_step(h1_base, fold_char(stage.text_byte));
      h2_word = hash_step(h2_base, fold_char(stage.text_byte));
      pt_word = pt_r + 1'b1;
    end

    // A word character on the last byte joins its word before it is closed.
    finish = !word || stage.last_byte;
    h1_fin = word ? h1_word : h1_r;
    h2_fin = word ? h2_word : h2_r;
    pt_fin = word ? pt_word : pt_r;

    mix_prod = {{(HASH_W-PW){1'b0}}, pt_fin} * LENGTH_MIX_LO;
    mix      = mix_prod[HASH_W-1:0];

    sig_new = acc_r;
    if (finish && (pt_fin != '0)) begin
      sig_new = acc_r | (SIG_W'(1) << (h1_fin ^ mix)) | (SIG_W'(1) << (h2_fin ^ mix));
    end

    h1_nxt = h1_r;
    h2_nxt = h2_r;
    pt_nxt = pt_r;
    acc_nxt = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (go) begin
      if (word) begin
        h1_nxt = h1_word;
        h2_nxt = h2_word;
        pt_nxt = pt_word;
      end
      if (finish) begin
        pt_nxt = '0;
      end
      acc_nxt = sig_new;
      if (stage.last_byte) begin
        acc_nxt = '0;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r        <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pt_r        <= pt_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hash values are only read while a word is open, so they need no reset.
  always_ff @(posedge clk) begin
    h1_r <= h1_nxt;
    h2_r <= h2_nxt;
    if (go && stage.last_byte) begin
      out_sig_r <= sig_new;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_signature = out_sig_r;

endmodule

// ===== rtl/text_word_bloom_signature.sv =====
// Top level of the text word signature block: seed registers and the two stages.
//
//   port group   direction  payload                     handshake
//   in_          sink       text_byte[7:0], last_byte    in_valid / in_stall
//   out_         source     signature[63:0]              out_valid / out_stall
//   cfg_         sink       index[1:0], wdata[31:0]      cfg_wr_en
//
// One text word is taken every cycle while in_stall is low; a word is held in the
// input register until the state update takes it, and the signature shows at the
// result register the cycle after its last word is processed.
// Synchronous active-low reset clears the word state, the signature and the
// seeds to their defaults; no clearing pass is needed.
// in_stall rises only when a final word waits behind a stalled result.
module text_word_bloom_signature #(
  parameter int PREFIX_LIMIT = tbws_pkg::PREFIX_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tbws_pkg::BYTE_W-1:0]    in_text_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tbws_pkg::SIG_W-1:0]     out_signature,
  input  logic                           cfg_wr_en,
  input  logic [tbws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbws_pkg::SEED_W-1:0]    cfg_wdata
);
  import tbws_pkg::*;

  logic [HASH_W-1:0] seed_one_r, seed_one_nxt, seed_two_r, seed_two_nxt;
  in_word_t          stage;
  logic              go;

  // Only the low bits of each seed can reach a signature bit.
  always_comb begin
    seed_one_nxt = seed_one_r;
    seed_two_nxt = seed_two_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_FIRST_SEED:  seed_one_nxt = cfg_wdata[HASH_W-1:0];
        REG_SECOND_SEED: seed_two_nxt = cfg_wdata[HASH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_one_r <= SEED_ONE_RESET[HASH_W-1:0];
      seed_two_r <= SEED_TWO_RESET[HASH_W-1:0];
    end else begin
      seed_one_r <= seed_one_nxt;
      seed_two_r <= seed_two_nxt;
    end
  end

  tbws_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .go           (go),
    .stage        (stage)
  );

  tbws_accum #(
    .PREFIX_LIMIT (PREFIX_LIMIT)
  ) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .stage         (stage),
    .seed_one      (seed_one_r),
    .seed_two      (seed_two_r),
    .go            (go),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_signature (out_signature)
  );

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !stage.valid |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_last_waits_for_result: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.valid && stage.last_byte && out_valid && out_stall) |-> (in_stall && !go))
    else $error("final word processed while the result register was blocked");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (go && stage.last_byte) |=> out_valid)
    else $error("final word processed without a result");

endmodule

// ===== bench/text_word_bloom_signature_tb.sv =====
// Self-checking testbench for the text word signature block.
module text_word_bloom_signature_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbws_pkg::*;

  localparam int N_RANDOM_BYTES = 1200;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;
    logic              typed;
    logic [SIG_W-1:0]  signature;
    logic              reseed;
  } text_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_text_byte = '0;
  logic                 in_last_byte = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SIG_W-1:0]     out_signature;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FIRST_SEED;
  logic [SEED_W-1:0]    cfg_wdata = '0;

  // Local copy of the seeds and of the per-text hashing state.
  logic [SEED_W-1:0] seed_one;
  logic [SEED_W-1:0] seed_two;
  logic [SEED_W-1:0] word_hash_one;
  logic [SEED_W-1:0] word_hash_two;
  logic [2:0]        word_len;
  logic [SIG_W-1:0]  sig_acc;

  logic [SIG_W-1:0] sig_expect [$];
  logic [SIG_W-1:0] want_sig;
  logic             steady = 1'b0;
  int               fail_count = 0;
  int               sig_checked = 0;
  int               sent_count = 0;
  int               seed_settings = 1;
  int               next_reseed = 0;

  // Directed texts: the wordless texts carry their signature here.
  text_row_t text_rows [0:25] = '{
    '{8'h00, 1'b1, 1'b1, 64'h0, 1'b0},
    '{8'h20, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h2F, 1'b1, 1'b1, 64'h0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h62, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h43, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h64, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h45, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h46, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h5A, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h40, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h30, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h39, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h5B, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h60, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h61, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h7A, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h7B, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'hFF, 1'b1, 1'b0, 64'h0, 1'b0},
    '{8'h71, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h3A, 1'b1, 1'b0, 64'h0, 1'b0},
    '{8'h78, 1'b0, 1'b0, 64'h0, 1'b0},
    '{8'h79, 1'b0, 1'b0, 64'h0, 1'b1},
    '{8'h7A, 1'b1, 1'b0, 64'h0, 1'b0}
  };

  text_word_bloom_signature DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_signature (out_signature),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall = rst_n && !steady && ($urandom_range(99) < 29);
  end

  function automatic logic is_text_char(input logic [BYTE_W-1:0] b);
    return b[7] || (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic [BYTE_W-1:0] rand_word_char();
    case ($urandom_range(3))
      0: return 8'(8'h41 + $urandom_range(25));
      1: return 8'(8'h61 + $urandom_range(25));
      2: return 8'(8'h30 + $urandom_range(9));
      default: return 8'(8'h80 + $urandom_range(127));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] rand_separator();
    case ($urandom_range(3))
      0: return 8'($urandom_range(8'h2F));
      1: return 8'($urandom_range(8'h3A, 8'h40));
      2: return 8'($urandom_range(8'h5B, 8'h60));
      default: return 8'($urandom_range(8'h7B, 8'h7F));
    endcase
  endfunction

  // Ends the text word in progress: its two hashes, each mixed with the prefix
  // length, set one signature bit apiece.
  task automatic close_text_word();
    logic [SEED_W-1:0] mix;
    if (word_len != 3'd0) begin
      mix = {29'd0, word_len} * LENGTH_MIX;
      sig_acc[(word_hash_one ^ mix) & 32'd63] = 1'b1;
      sig_acc[(word_hash_two ^ mix) & 32'd63] = 1'b1;
    end
    word_len      = 3'd0;
    word_hash_one = seed_one;
    word_hash_two = seed_two;
  endtask

  task automatic fold_text_byte(input logic [BYTE_W-1:0] b, input logic last,
                                output logic emit, output logic [SIG_W-1:0] sig);
    logic [SEED_W-1:0] c;
    emit = 1'b0;
    sig  = '0;
    if (is_text_char(b)) begin
      if (word_len == 3'd0) begin
        word_hash_one = seed_one;
        word_hash_two = seed_two;
      end
      if (word_len < 3'(PREFIX_LIMIT_DEF)) begin
        c = {24'd0, b};
        if (b inside {[8'h41:8'h5A]}) begin
          c = c + 32'h20;
        end
        word_hash_one = (word_hash_one ^ c) * FNV_PRIME;
        word_hash_two = (word_hash_two ^ c) * FNV_PRIME;
        word_len      = word_len + 3'd1;
      end
    end else begin
      close_text_word();
    end
    if (last) begin
      close_text_word();
      emit    = 1'b1;
      sig     = sig_acc;
      sig_acc = '0;
    end
  endtask

  task automatic report_fail(input string what, input logic [SIG_W-1:0] want,
                             input logic [SIG_W-1:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s signature expected %h got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sig_expect.size() == 0) begin
        report_fail("unexpected", '0, out_signature);
      end else begin
        want_sig = sig_expect.pop_front();
        if (want_sig !== out_signature) begin
          report_fail("wrong", want_sig, out_signature);
        end else begin
          sig_checked++;
        end
      end
    end
  end

  // Called just after a falling edge; returns just after the falling edge that
  // follows the accepting rising edge.
  task automatic push_word(input logic [BYTE_W-1:0] b, input logic last,
                           input logic use_typed, input logic [SIG_W-1:0] typed_sig);
    logic             emit;
    logic [SIG_W-1:0] sig;
    steady = (sent_count >= 600) && (sent_count < 800);
    while (!steady && ($urandom_range(99) < 29)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_text_byte = b;
    in_last_byte = last;
    do @(posedge clk); while (in_stall);
    fold_text_byte(b, last, emit, sig);
    if (emit) begin
      sig_expect.push_back(use_typed ? typed_sig : sig);
    end
    sent_count++;
    @(negedge clk);
  endtask

  // Lets the block drain completely, then loads the next pair of seeds. A
  // drain may fall inside a text, even inside a text word.
  task automatic pause_and_reseed();
    logic [SEED_W-1:0] one;
    logic [SEED_W-1:0] two;
    in_valid = 1'b0;
    wait (sig_expect.size() == 0);
    @(negedge clk);
    repeat (8) @(negedge clk);
    case (seed_settings)
      1: begin one = 32'h0;          two = 32'hFFFF_FFFF; end
      2: begin one = 32'hFFFF_FFFF;  two = 32'h0;         end
      3: begin one = 32'h0;          two = 32'h0;         end
      4: begin one = 32'hFFFF_FFFF;  two = 32'hFFFF_FFFF; end
      5: begin one = SEED_ONE_RESET; two = SEED_TWO_RESET; end
      default: begin one = $urandom(); two = $urandom(); end
    endcase
    cfg_wr_en = 1'b1;
    cfg_index = REG_FIRST_SEED;
    cfg_wdata = one;
    @(negedge clk);
    cfg_index = REG_SECOND_SEED;
    cfg_wdata = two;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    seed_one  = one;
    seed_two  = two;
    seed_settings++;
  endtask

  // Mostly well-formed texts of short and long text words; one in eight is
  // raw noise.
  task automatic send_random_text();
    logic [BYTE_W-1:0] text_q [$];
    int                n_words;
    int                n_noise;
    if ($urandom_range(7) == 0) begin
      n_noise = $urandom_range(1, 20);
      repeat (n_noise) text_q.push_back(8'($urandom_range(255)));
    end else begin
      n_words = $urandom_range(0, 5);
      repeat ($urandom_range(0, 1)) text_q.push_back(rand_separator());
      for (int w = 0; w < n_words; w++) begin
        if (w > 0) begin
          repeat ($urandom_range(1, 2)) text_q.push_back(rand_separator());
        end
        repeat ($urandom_range(1, 8)) text_q.push_back(rand_word_char());
      end
      if ((n_words == 0) || ($urandom_range(1) == 1)) begin
        text_q.push_back(rand_separator());
      end
    end
    foreach (text_q[i]) begin
      push_word(text_q[i], i == text_q.size() - 1, 1'b0, '0);
      if (sent_count >= next_reseed) begin
        pause_and_reseed();
        next_reseed = sent_count + $urandom_range(150, 250);
      end
    end
  endtask

  initial begin
    seed_one      = SEED_ONE_RESET;
    seed_two      = SEED_TWO_RESET;
    word_hash_one = SEED_ONE_RESET;
    word_hash_two = SEED_TWO_RESET;
    word_len      = 3'd0;
    sig_acc       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (text_rows[i]) begin
      push_word(text_rows[i].text_byte, text_rows[i].last_byte, text_rows[i].typed,
                text_rows[i].signature);
      if (text_rows[i].reseed) begin
        pause_and_reseed();
      end
    end

    next_reseed = sent_count + $urandom_range(150, 250);
    while (sent_count < $size(text_rows) + N_RANDOM_BYTES) begin
      send_random_text();
    end
    in_valid = 1'b0;
    steady   = 1'b0;

    wait (sig_expect.size() == 0);
    repeat (10) @(posedge clk);
    if (sig_expect.size() != 0) begin
      fail_count++;
    end
    $display("Fed %0d text bytes under %0d seed settings; %0d signatures matched.",
             sent_count, seed_settings, sig_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("Test completed with failures");
    $finish;
  end

endmodule
